>>> design/tpt_pkg.sv
// ----------------------------------------------------------------------------
// Tag presence table package
// Shared types, command and status codes, and table constants.
// ----------------------------------------------------------------------------
`default_nettype none

package tpt_pkg;

  // Default table depth.
  localparam int ENTRIES_DEF = 32;

  // Number of low sensor bytes that a tag record writes.
  localparam int SENSOR_LEN = 4;

  // Marker byte value of a free entry.
  localparam logic [7:0] EMPTY_BYTE = 8'hFF;

  // Commands.
  localparam logic [1:0] CMD_TAG    = 2'd0;
  localparam logic [1:0] CMD_READER = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_READ   = 2'd3;

  // Result status codes.
  localparam logic [2:0] ST_UPDATED  = 3'd0;
  localparam logic [2:0] ST_INSERTED = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_CLEARED  = 3'd3;
  localparam logic [2:0] ST_READ     = 3'd4;

  // Byte mask over the sensor data for the low len bytes.
  function automatic logic [31:0] sensor_mask(input int len);
    logic [31:0] m;
    m = '0;
    for (int b = 0; b < 4; b++) begin
      if (b < len) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

  // One input word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] dev_id;
    logic [7:0]  dev_state;
    logic [7:0]  sensor_kind;
    logic [31:0] sensor_bytes;
    logic [7:0]  sw_version;
    logic [6:0]  rssi_sample;
    logic [4:0]  read_slot;
  } item_word_t;

  // One result word.
  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  slot;
    logic [31:0] entry_id;
    logic [7:0]  entry_state;
    logic [7:0]  entry_sensor_kind;
    logic [31:0] entry_sensor_bytes;
    logic [7:0]  entry_version;
    logic [7:0]  entry_rssi;
    logic [15:0] entry_leave;
  } result_word_t;

endpackage

`default_nettype wire

>>> design/tpt_item_if.sv
// ----------------------------------------------------------------------------
// Tag presence table input channel
// Valid/ready channel that carries one command word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_item_if;
  logic                valid;
  logic                ready;
  tpt_pkg::item_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tpt_result_if.sv
// ----------------------------------------------------------------------------
// Tag presence table result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tpt_result_if;
  logic                  valid;
  logic                  ready;
  tpt_pkg::result_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/tag_presence_table.sv
// ----------------------------------------------------------------------------
// Tag presence table
// Table of seen radio devices with lookup-or-insert, clear and entry read.
// ----------------------------------------------------------------------------
// Usage: commands enter as words on the item channel and each gives exactly
// one word on the result channel. Both channels transfer a word when valid
// and ready are high at a rising clock edge.
// A record command scans the table one entry per cycle through the single
// read port of the entry memory and one shared ID comparator, then writes
// the entry. A match ends the scan early; otherwise the scan reads every
// entry and writes the first free one, or gives a full status if none is.
// A read command passes through a wait state for the registered memory read.
// Only one command is in work at a time; item.ready returns in the cycle after
// the result word is produced, even when that word still waits on the result
// channel. A stalled receiver holds the result register, and the next
// command then waits at its end until that register frees up.
// Reset (synchronous, rst) holds item.ready low and clears the per-entry
// valid bits, so every entry reads as all ones (empty) right away; clear
// does the same.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_presence_table #(
  parameter int ENTRIES = tpt_pkg::ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  tpt_item_if.sink            item,
  tpt_result_if.source        result
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [31:0] SensorMask = tpt_pkg::sensor_mask(tpt_pkg::SENSOR_LEN);

  typedef struct packed {
    logic [31:0] id;
    logic [7:0]  state;
    logic [7:0]  kind;
    logic [31:0] sensor;
    logic [7:0]  version;
    logic [7:0]  rssi;
    logic [15:0] leave;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_RDWT  = 5'b00100,
    S_WRITE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // Entry memory and its valid bits.
  entry_t             mem [ENTRIES];
  logic [ENTRIES-1:0] valid;
  entry_t             rd_q;
  logic               rd_ok;

  logic               mem_we;
  logic [IW-1:0]      mem_wa;
  entry_t             mem_wd;
  logic [IW-1:0]      mem_ra;
  logic               clr;

  // Item and sequencer registers.
  tpt_pkg::item_word_t   item_q;
  logic [IW:0]           iss, iss_next;
  logic                  rd_vld, rd_vld_next;
  logic [IW-1:0]         rd_idx, rd_idx_next;
  logic                  have_free, have_free_next;
  logic [IW-1:0]         free_idx, free_idx_next;
  entry_t                free_ent, free_ent_next;
  logic                  found, found_next;
  logic [IW-1:0]         tgt, tgt_next;
  entry_t                ent_q, ent_q_next;
  tpt_pkg::result_word_t res, res_next;

  // Output register.
  logic                  out_vld;
  tpt_pkg::result_word_t out_q;

  // Scan compare on the entry just read.
  entry_t       cur;
  logic [7:0]   marker;
  logic         is_free;
  logic         is_hit;
  logic         is_reader;
  entry_t       wr_ent;
  logic [IW+4:0] rs_ext;
  logic         rs_oor;
  logic [IW+4:0] tgt_ext;

  assign cur       = rd_ok ? rd_q : '1;
  assign is_reader = (item_q.cmd == tpt_pkg::CMD_READER);
  assign marker    = is_reader ? cur.id[31:24] : cur.id[7:0];
  assign is_free   = (marker == tpt_pkg::EMPTY_BYTE);
  assign is_hit    = !is_free && (cur.id == item_q.dev_id);

  assign rs_ext  = {{IW{1'b0}}, item.data.read_slot};
  assign rs_oor  = (rs_ext >= (IW+5)'(ENTRIES));
  assign tgt_ext = {5'd0, tgt};

  // Merged entry that a record writes.
  always_comb begin
    wr_ent = ent_q;
    if (!found) begin
      wr_ent.id = item_q.dev_id;
    end
    wr_ent.state   = item_q.dev_state;
    wr_ent.version = item_q.sw_version;
    wr_ent.rssi    = {1'b0, item_q.rssi_sample};
    if (!is_reader) begin
      wr_ent.kind   = item_q.sensor_kind;
      wr_ent.sensor = (ent_q.sensor & ~SensorMask) | (item_q.sensor_bytes & SensorMask);
      wr_ent.leave  = '0;
    end
  end

  // Sequencer.
  always_comb begin
    state_next     = state;
    iss_next       = iss;
    rd_vld_next    = 1'b0;
    rd_idx_next    = rd_idx;
    have_free_next = have_free;
    free_idx_next  = free_idx;
    free_ent_next  = free_ent;
    found_next     = found;
    tgt_next       = tgt;
    ent_q_next     = ent_q;
    res_next       = res;
    mem_we         = 1'b0;
    mem_wa         = tgt;
    mem_wd         = wr_ent;
    mem_ra         = iss[IW-1:0];
    clr            = 1'b0;

    case (state)
      S_IDLE: begin
        mem_ra = rs_ext[IW-1:0];
        if (item.valid) begin
          case (item.data.cmd)
            tpt_pkg::CMD_CLEAR: begin
              clr             = 1'b1;
              res_next        = '0;
              res_next.status = tpt_pkg::ST_CLEARED;
              state_next      = S_EMIT;
            end
            tpt_pkg::CMD_READ: begin
              res_next        = '1;
              res_next.status = tpt_pkg::ST_READ;
              res_next.slot   = item.data.read_slot;
              found_next      = !rs_oor;
              state_next      = S_RDWT;
            end
            default: begin
              iss_next       = '0;
              have_free_next = 1'b0;
              state_next     = S_SCAN;
            end
          endcase
        end
      end

      S_RDWT: begin
        if (found) begin
          res_next.entry_id           = cur.id;
          res_next.entry_state        = cur.state;
          res_next.entry_sensor_kind  = cur.kind;
          res_next.entry_sensor_bytes = cur.sensor;
          res_next.entry_version      = cur.version;
          res_next.entry_rssi         = cur.rssi;
          res_next.entry_leave        = cur.leave;
        end
        state_next = S_EMIT;
      end

      S_SCAN: begin
        // Issue the next read while the previous entry is compared.
        if (iss < (IW+1)'(ENTRIES)) begin
          rd_vld_next = 1'b1;
          rd_idx_next = iss[IW-1:0];
          iss_next    = iss + 1'b1;
        end
        if (rd_vld) begin
          if (is_free && !have_free) begin
            have_free_next = 1'b1;
            free_idx_next  = rd_idx;
            free_ent_next  = cur;
          end
          if (is_hit) begin
            found_next  = 1'b1;
            tgt_next    = rd_idx;
            ent_q_next  = cur;
            state_next  = S_WRITE;
          end else if (rd_idx == IW'(ENTRIES - 1)) begin
            found_next = 1'b0;
            if (have_free) begin
              tgt_next   = free_idx;
              ent_q_next = free_ent;
              state_next = S_WRITE;
            end else if (is_free) begin
              tgt_next   = rd_idx;
              ent_q_next = cur;
              state_next = S_WRITE;
            end else begin
              res_next        = '0;
              res_next.status = tpt_pkg::ST_FULL;
              state_next      = S_EMIT;
            end
          end
        end
      end

      S_WRITE: begin
        mem_we                      = 1'b1;
        res_next.status             = found ? tpt_pkg::ST_UPDATED : tpt_pkg::ST_INSERTED;
        res_next.slot               = tgt_ext[4:0];
        res_next.entry_id           = wr_ent.id;
        res_next.entry_state        = wr_ent.state;
        res_next.entry_sensor_kind  = wr_ent.kind;
        res_next.entry_sensor_bytes = wr_ent.sensor;
        res_next.entry_version      = wr_ent.version;
        res_next.entry_rssi         = wr_ent.rssi;
        res_next.entry_leave        = wr_ent.leave;
        state_next                  = S_EMIT;
      end

      S_EMIT: begin
        if (!out_vld || result.ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign item.ready = (state == S_IDLE) && !rst;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rd_vld    <= 1'b0;
      have_free <= 1'b0;
      found     <= 1'b0;
      iss       <= '0;
    end else begin
      state     <= state_next;
      rd_vld    <= rd_vld_next;
      have_free <= have_free_next;
      found     <= found_next;
      iss       <= iss_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      item_q <= item.data;
    end
    rd_idx   <= rd_idx_next;
    free_idx <= free_idx_next;
    free_ent <= free_ent_next;
    tgt      <= tgt_next;
    ent_q    <= ent_q_next;
    res      <= res_next;
  end

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q <= mem[mem_ra];
  end

  // Valid bits: an entry that is not valid reads as all ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= valid[mem_ra];
      if (clr) begin
        valid <= '0;
      end else if (mem_we) begin
        valid[mem_wa] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (state == S_EMIT && (!out_vld || result.ready)) begin
      out_vld <= 1'b1;
    end else if (result.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && (!out_vld || result.ready)) begin
      out_q <= res;
    end
  end

  assign result.valid = out_vld;
  assign result.data  = out_q;

endmodule

`default_nettype wire
